### hw/rtl/prts_pkg.sv
// ----------------------------------------------------------------------------
// prts_pkg
// Shared types and constants of the phasor rhythm trigger sequencer.
// ----------------------------------------------------------------------------
package prts_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int MAX_STEPS   = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W       = 24;
   localparam int ONSET_W     = POS_W + 1;
   localparam int DIV_STEPS   = POS_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int ENTRY_W     = ONSET_W + POS_W;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [15:0] BEAT_RESET = 16'd22050;
   localparam logic [12:0] WRAP_RESET = 13'd64;

   // register index decoded from the address
   localparam logic CSR_BEAT = 1'b0;
   localparam logic CSR_WRAP = 1'b1;

   // item kinds
   localparam logic REQ_GROUP = 1'b0;
   localparam logic REQ_AUDIO = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] group_beats;
      logic [31:0] pattern_bits;
      logic [5:0]  pattern_steps;
      logic        first_group;
      logic        last_group;
      logic [15:0] phase;
   } req_item_type;

   typedef struct packed {
      logic [5:0]  note_index;
      logic [23:0] note_duration;
   } rsp_item_type;

   typedef enum logic [1:0] {
      MUL_BAR,
      MUL_POS,
      MUL_NOTE
   } mul_op_type;

   typedef struct packed {
      logic       load_item;
      logic       div_step;
      logic       walk_step;
      logic       finish_group;
      logic       mul_en;
      mul_op_type mul_op;
      logic       decide;
   } cmd_type;

   typedef struct packed {
      logic walk_last;
      logic out_full;
   } status_type;

endpackage

### hw/rtl/prts_ram.sv
// ----------------------------------------------------------------------------
// prts_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module prts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write or read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/prts_ctrl.sv
// ----------------------------------------------------------------------------
// prts_ctrl
// Sequencer: steps the divider, the step walk and the shared multiplier.
// ----------------------------------------------------------------------------
module prts_ctrl
   import prts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_item_type req_data,
   output logic         req_stall,
   input  status_type   status,
   output cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_WALK,
      S_FINISH,
      S_MUL_BAR,
      S_MUL_POS,
      S_MUL_NOTE,
      S_DECIDE
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // decode commands and next state
   always_comb begin
      cmd      = '0;
      cmd.mul_op = MUL_BAR;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cnt_in = '0;
               if (req_data.req_type == REQ_AUDIO) begin
                  state_in = S_MUL_BAR;
               end else if (req_data.pattern_steps == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish_group = 1'b1;
            state_in = S_IDLE;
         end
         S_MUL_BAR: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_BAR;
            state_in = S_MUL_POS;
         end
         S_MUL_POS: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_POS;
            state_in = S_MUL_NOTE;
         end
         S_MUL_NOTE: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_NOTE;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // wait for the output register to drain
            if (!status.out_full) begin
               cmd.decide = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted item did not make the block busy");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff != DIV_CNT_W'(DIV_STEPS - 1)) |=> state_ff == S_DIV)
      else $error("divider left early");
`endif

endmodule

### hw/rtl/prts_dp.sv
// ----------------------------------------------------------------------------
// prts_dp
// Datapath: registers, divider, onset walk, note table, multiplier, output.
// ----------------------------------------------------------------------------
module prts_dp
   import prts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_data,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_item_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata
);

   logic [15:0]        beat_ff;
   logic [12:0]        wrap_ff;
   logic [POS_W-1:0]   beats_ff;
   logic [31:0]        bits_ff;
   logic [5:0]         steps_ff;
   logic               last_ff;
   logic [15:0]        phase_ff;
   logic [POS_W-1:0]   build_pos_ff;
   logic [COUNT_W-1:0] build_cnt_ff;
   logic [POS_W-1:0]   bar_len_ff;
   logic [COUNT_W-1:0] active_ff;
   logic [COUNT_W-1:0] play_ff;
   logic [POS_W-1:0]   div_q_ff;
   logic [5:0]         div_r_ff;
   logic [POS_W-1:0]   acc_q_ff;
   logic [5:0]         acc_r_ff;
   logic [5:0]         j_ff;
   logic [POS_W-1:0]   bar_samps_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [ONSET_W-1:0] note_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;

   logic [5:0]         steps_clamp;
   logic [6:0]         div_t;
   logic               div_ge;
   logic [6:0]         acc_sum;
   logic               acc_wrap;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [ONSET_W-1:0] rd_onset;
   logic [POS_W-1:0]   rd_dur;
   logic [ONSET_W-1:0] mul_a;
   logic [15:0]        mul_b;
   logic [40:0]        prod;
   logic [ONSET_W-1:0] pos_sum;
   logic               playable;
   logic               fire;
   logic               csr_wr;

   assign steps_clamp = (req_data.pattern_steps > 6'(MAX_STEPS)) ? 6'(MAX_STEPS)
                                                                 : req_data.pattern_steps;

   // restoring divider step
   assign div_t  = {div_r_ff, div_q_ff[POS_W-1]};
   assign div_ge = (div_t >= {1'b0, steps_ff});

   // running remainder of beats*j/steps
   assign acc_sum  = {1'b0, acc_r_ff} + {1'b0, div_r_ff};
   assign acc_wrap = (acc_sum >= {1'b0, steps_ff});

   // note table port
   assign ram_we    = cmd.walk_step && bits_ff[j_ff[4:0]] &&
                      (build_cnt_ff < COUNT_W'(TABLE_DEPTH));
   assign ram_addr  = cmd.load_item ? play_ff[ADDR_W-1:0] : build_cnt_ff[ADDR_W-1:0];
   assign ram_wdata = {({1'b0, build_pos_ff} + {1'b0, acc_q_ff}), div_q_ff};

   prts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (cmd.load_item),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign rd_onset = ram_rdata[ENTRY_W-1:POS_W];
   assign rd_dur   = ram_rdata[POS_W-1:0];

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_op)
         MUL_BAR: begin
            mul_a = {1'b0, bar_len_ff};
            mul_b = beat_ff;
         end
         MUL_POS: begin
            mul_a = {1'b0, bar_samps_ff};
            mul_b = phase_ff;
         end
         MUL_NOTE: begin
            mul_a = rd_onset;
            mul_b = beat_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign pos_sum  = {1'b0, build_pos_ff} + {1'b0, beats_ff};
   assign playable = (play_ff < active_ff);
   assign fire     = playable && ({1'b0, pos_ff} > note_ff);
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= BEAT_RESET;
         wrap_ff <= WRAP_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_BEAT: beat_ff <= csr_pwdata[15:0];
            CSR_WRAP: wrap_ff <= csr_pwdata[12:0];
            default:  beat_ff <= beat_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_BEAT: csr_prdata = {16'd0, beat_ff};
         CSR_WRAP: csr_prdata = {19'd0, wrap_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // pattern state
   always_ff @(posedge clock) begin
      if (reset) begin
         build_pos_ff <= '0;
         build_cnt_ff <= '0;
         bar_len_ff   <= '0;
         active_ff    <= '0;
         play_ff      <= '0;
      end else begin
         if (cmd.load_item && req_data.req_type == REQ_GROUP && req_data.first_group) begin
            build_pos_ff <= '0;
            build_cnt_ff <= '0;
         end
         if (ram_we) begin
            build_cnt_ff <= build_cnt_ff + 1'b1;
         end
         if (cmd.finish_group) begin
            build_pos_ff <= pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
            if (last_ff) begin
               bar_len_ff <= pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
               active_ff  <= build_cnt_ff;
            end
         end
         if (cmd.decide) begin
            if (fire) begin
               play_ff <= play_ff + 1'b1;
            end else if (!playable && ({11'd0, wrap_ff} > pos_ff)) begin
               play_ff <= '0;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         beats_ff <= {req_data.group_beats, 8'd0};
         bits_ff  <= req_data.pattern_bits;
         steps_ff <= steps_clamp;
         last_ff  <= req_data.last_group;
         phase_ff <= req_data.phase;
         div_q_ff <= {req_data.group_beats, 8'd0};
         div_r_ff <= '0;
         acc_q_ff <= '0;
         acc_r_ff <= '0;
         j_ff     <= '0;
      end
      if (cmd.div_step) begin
         div_q_ff <= {div_q_ff[POS_W-2:0], div_ge};
         div_r_ff <= div_ge ? 6'(div_t - {1'b0, steps_ff}) : div_t[5:0];
      end
      if (cmd.walk_step) begin
         j_ff <= j_ff + 1'b1;
         if (acc_wrap) begin
            acc_r_ff <= 6'(acc_sum - {1'b0, steps_ff});
            acc_q_ff <= acc_q_ff + div_q_ff + 1'b1;
         end else begin
            acc_r_ff <= acc_sum[5:0];
            acc_q_ff <= acc_q_ff + div_q_ff;
         end
      end
      if (cmd.mul_en) begin
         case (cmd.mul_op)
            MUL_BAR:  bar_samps_ff <= prod[39:16];
            MUL_POS:  pos_ff       <= prod[39:16];
            MUL_NOTE: note_ff      <= prod[40:16];
            default:  note_ff      <= note_ff;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.decide && fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide && fire) begin
         rsp_ff.note_index    <= play_ff[5:0];
         rsp_ff.note_duration <= rd_dur;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign status.walk_last = (j_ff == 6'(steps_ff - 1'b1));
   assign status.out_full  = rsp_valid_ff && rsp_stall;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      build_cnt_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("note count past table depth");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (acc_r_ff < steps_ff && div_r_ff < steps_ff))
      else $error("step remainder out of range");
   a_fire_out: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && fire) |=> rsp_valid)
      else $error("fired note not presented");
`endif

endmodule

### hw/rtl/phasor_rhythm_trigger_sequencer.sv
// ----------------------------------------------------------------------------
// phasor_rhythm_trigger_sequencer
// Step sequencer that builds a note table from rhythm groups and fires the
// notes as a bar phase advances.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a rhythm group load (req_type 0) or an audio
//   sample with its bar phase (req_type 1). rsp_* carries one fired note,
//   its table index and duration. csr_* is an APB-style port for
//   beat_samples (address 0) and wrap_window (address 4).
//   Group load: accept, the bit-serial divider that splits the group into
//   steps, one walk step per pattern step to write the note table, then
//   the bar position advance; zero-step groups skip divider and walk.
//   Audio sample: three products through one shared multiplier, then the
//   decision; a fired note appears in the output register afterwards.
//   One item is worked on at a time; req_stall is high while busy.
//   A waiting result does not block the next item; only an audio sample
//   that reaches its decision while the output register is still stalled
//   waits for it to drain.
//   Reset clears the bar, counts and play index and loads the register
//   defaults; the note table needs no clearing.
// ----------------------------------------------------------------------------
module phasor_rhythm_trigger_sequencer
   import prts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cmd_type    cmd;
   status_type status;

   prts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   prts_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

   assign csr_pready = 1'b1;

endmodule

### bench/tb_phasor_rhythm_trigger_sequencer.sv
// ----------------------------------------------------------------------------
// tb_phasor_rhythm_trigger_sequencer
// Drives rhythm group loads and audio samples with bursty valid and random
// result stall, predicts every fired note and checks each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_phasor_rhythm_trigger_sequencer;
   import prts_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   phasor_rhythm_trigger_sequencer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   logic [31:0]  note_onset [TABLE_DEPTH];
   logic [23:0]  note_dur [TABLE_DEPTH];
   logic [23:0]  bar_pos;
   logic [6:0]   bar_notes;
   logic [23:0]  bar_len;
   logic [6:0]   live_notes;
   logic [6:0]   next_note;
   logic [15:0]  beat_len;
   logic [12:0]  rewind_win;

   req_item_type pending_items[$];
   rsp_item_type fired_notes[$];
   int           fail_count;
   int           burst_left;
   int           gap_left;
   int           stall_mode;
   int           stall_left;
   int           done_items;
   int           sent_items;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("tb_phasor_rhythm_trigger_sequencer NOT OK");
      $finish;
   end

   // predict one accepted item, pushing the fired note if any
   function automatic void predict_item(req_item_type it);
      logic [39:0] beats;
      int          steps;
      logic [63:0] sum;
      logic [63:0] bar_s;
      logic [63:0] posn;
      logic [63:0] nsamp;
      rsp_item_type r;
      if (it.req_type == REQ_GROUP) begin
         beats = {16'd0, it.group_beats, 8'd0};
         steps = it.pattern_steps;
         if (it.first_group) begin
            bar_pos = '0;
            bar_notes = '0;
         end
         if (steps > MAX_STEPS) steps = MAX_STEPS;
         for (int j = 0; j < steps; j++) begin
            if (it.pattern_bits[j] && bar_notes < TABLE_DEPTH) begin
               note_dur[bar_notes] = 24'(beats / steps);
               note_onset[bar_notes] = 32'(bar_pos + (beats * j) / steps);
               bar_notes++;
            end
         end
         sum = 64'(bar_pos) + beats;
         bar_pos = (sum > 64'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
         if (it.last_group) begin
            bar_len = bar_pos;
            live_notes = bar_notes;
         end
      end else begin
         bar_s = (64'(bar_len) * beat_len) >> 16;
         posn = (bar_s * it.phase) >> 16;
         if (next_note < live_notes && next_note < TABLE_DEPTH) begin
            nsamp = (64'(note_onset[next_note]) * beat_len) >> 16;
            if (posn > nsamp) begin
               r.note_index = next_note[5:0];
               r.note_duration = note_dur[next_note];
               fired_notes.push_back(r);
               next_note++;
            end
         end else if (posn < rewind_win) begin
            next_note = '0;
         end
      end
   endfunction

   // driver: bursts with gaps, hold payload until it is accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && (done_items != sent_items)) begin
         req_valid <= 1'b1;
      end else begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            sent_items = sent_items + 1;
            if (burst_left > 0) burst_left = burst_left - 1;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      // receiver stall pattern
      if (stall_left > 0) stall_left = stall_left - 1;
      else begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(5, 80);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= (stall_left % 16) < 12;
      endcase
   end

   // monitor: predict accepted items, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_item(req_data);
            done_items++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (fired_notes.size() == 0) begin
               $error("unexpected note index %0d", rsp_data.note_index);
               fail_count++;
            end else begin
               rsp_item_type e;
               e = fired_notes.pop_front();
               if (e.note_index !== rsp_data.note_index) begin
                  $error("note_index expected %0d actual %0d",
                         e.note_index, rsp_data.note_index);
                  fail_count++;
               end
               if (e.note_duration !== rsp_data.note_duration) begin
                  $error("note_duration expected %0h actual %0h",
                         e.note_duration, rsp_data.note_duration);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic csr_write(input logic idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == CSR_BEAT) beat_len = val[15:0];
      else rewind_win = val[12:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // wait for all queued items to be taken and all notes to drain
   task automatic drain_all();
      int tries;
      tries = 0;
      while ((pending_items.size() > 0 || req_valid || fired_notes.size() > 0
              || req_stall) && tries < 2000000) begin
         @(posedge clock);
         tries++;
      end
      if (tries >= 2000000) begin
         $display("tb_phasor_rhythm_trigger_sequencer NOT OK");
         $finish;
      end
      repeat (80) @(posedge clock);
   endtask

   function automatic req_item_type make_group(logic [15:0] b, logic [31:0] bits,
                                               logic [5:0] st, logic f, logic l);
      req_item_type it;
      it = '0;
      it.req_type = REQ_GROUP;
      it.group_beats = b;
      it.pattern_bits = bits;
      it.pattern_steps = st;
      it.first_group = f;
      it.last_group = l;
      it.phase = 16'($urandom);
      return it;
   endfunction

   function automatic req_item_type make_audio(logic [15:0] ph);
      req_item_type it;
      it = req_item_type'(73'({$urandom, $urandom, $urandom}));
      it.req_type = REQ_AUDIO;
      it.phase = ph;
      return it;
   endfunction

   // one bar built from random groups, then a phase sweep over it
   task automatic queue_bar(int ngroups, int nsamples);
      int   ph;
      int   stride;
      for (int g = 0; g < ngroups; g++) begin
         logic [5:0] st;
         st = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
         pending_items.push_back(make_group(16'($urandom_range(64, 1024)),
            $urandom, st, g == 0, g == ngroups - 1));
      end
      ph = 0;
      stride = 65536 / nsamples + 1;
      for (int s = 0; s < nsamples; s++) begin
         if ($urandom_range(0, 15) == 0) pending_items.push_back(make_audio(16'($urandom)));
         else pending_items.push_back(make_audio(16'(ph)));
         ph = ph + $urandom_range(0, 2 * stride);
         if (ph > 65535) ph = $urandom_range(0, 40);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      fail_count = 0;
      burst_left = 0;
      gap_left = 0;
      stall_mode = 0;
      stall_left = 0;
      done_items = 0;
      sent_items = 0;
      bar_pos = '0;
      bar_notes = '0;
      bar_len = '0;
      live_notes = '0;
      next_note = '0;
      beat_len = BEAT_RESET;
      rewind_win = WRAP_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         note_onset[i] = '0;
         note_dur[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: audio before any bar, extremes, special cases
      pending_items.push_back(make_audio(16'hFFFF));
      pending_items.push_back(make_audio(16'h0000));
      pending_items.push_back(make_group(16'h0000, 32'hFFFFFFFF, 6'd0, 1'b1, 1'b0));
      pending_items.push_back(make_group(16'hFFFF, 32'hFFFFFFFF, 6'd63, 1'b0, 1'b0));
      pending_items.push_back(make_group(16'hFFFF, 32'hFFFFFFFF, 6'd32, 1'b0, 1'b0));
      pending_items.push_back(make_group(16'hFFFF, 32'h80000001, 6'd33, 1'b0, 1'b1));
      pending_items.push_back(make_audio(16'h0000));
      pending_items.push_back(make_audio(16'h8000));
      pending_items.push_back(make_audio(16'hFFFF));
      pending_items.push_back(make_group(16'h0100, 32'h00000005, 6'd1, 1'b1, 1'b1));
      pending_items.push_back(make_audio(16'hFFFF));
      pending_items.push_back(make_audio(16'hFFFF));
      pending_items.push_back(make_audio(16'h0000));
      pending_items.push_back(make_audio(16'hFFFF));
      drain_all();

      // several register settings, extremes included
      for (int phase_no = 0; phase_no < 13; phase_no++) begin
         case (phase_no)
            0: begin csr_write(CSR_BEAT, 32'd1); csr_write(CSR_WRAP, 32'd1); end
            1: begin csr_write(CSR_BEAT, 32'd65535); csr_write(CSR_WRAP, 32'd4096); end
            2: begin csr_write(CSR_BEAT, 32'd0); csr_write(CSR_WRAP, 32'd0); end
            3: begin csr_write(CSR_BEAT, 32'hFFFFFFFF); csr_write(CSR_WRAP, 32'hFFFFFFFF); end
            default: begin
               csr_write(CSR_BEAT, $urandom_range(100, 3000));
               csr_write(CSR_WRAP, $urandom_range(1, 300));
            end
         endcase
         for (int b = 0; b < 3; b++) queue_bar($urandom_range(1, 4), $urandom_range(20, 60));
         // live rebuild without a first group, partial bar
         pending_items.push_back(make_group(16'($urandom), $urandom, 6'($urandom), 1'b0,
                                            1'($urandom)));
         drain_all();
      end

      if (fail_count == 0) begin
         $display("tb_phasor_rhythm_trigger_sequencer OK");
      end else begin
         $display("tb_phasor_rhythm_trigger_sequencer NOT OK");
      end
      $finish;
   end

endmodule
